[rtl/tcbm_pkg.sv]
// Shared constants, codes and control types for the transitive closure core.
package tcbm_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int VERTEX_W         = 6;
  localparam int ROW_W            = 32;
  localparam int MODE_W           = 2;

  localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(32);

  // Stream word layouts
  localparam int S_TDATA_W  = 16;
  localparam int M_FIELDS_W = VERTEX_W + 2 * ROW_W;
  localparam int M_TDATA_W  = 72;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_e;

  typedef struct packed {
    logic clear;
    logic add_edge;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

[rtl/transitive_closure_bit_matrix_core.sv]
// Top level of the transitive closure core: stream ports, controller and datapath.
//
// Slave stream: one word per command (clear both matrices, add an edge, or
// run the closure). Clear and edge words leave the core ready again in the
// next cycle; edges naming vertices outside 1..n are dropped.
// A closure word runs n row-parallel passes (one pass per pivot k, where n is
// the clamped vertex count), then emits n rows, one word per cycle on the
// master stream while the receiver keeps up, tlast on the row of vertex n.
// The slave side stays not ready until the last row has entered the output
// register.
// Master stream: rows leave through one output register; a stalled receiver
// holds the current row and pauses emission, nothing is lost.
// cfg_we_i writes the vertex count; write it only while the core is idle.
// Reset clears both matrices, sets the vertex count to 32 and empties the
// output register.
module transitive_closure_bit_matrix_core
  import tcbm_pkg::*;
#(
  parameter int MaxVertices = MAX_VERTICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [VERTEX_W-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // mode[1:0], src_vertex[7:2], dst_vertex[13:8]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // row_vertex[5:0], adjacency_row[37:6],
                                              // reach_row[69:38]
  output logic                 m_axis_tlast
);

  localparam int IdxW = $clog2(MaxVertices);

  cmd_t                cmd;
  status_t             status;
  logic [IdxW-1:0]     idx;
  logic [VERTEX_W-1:0] row_vertex;
  logic [ROW_W-1:0]    adjacency_row, reach_row;

  tcbm_ctrl #(
    .MaxVertices(MaxVertices),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .mode_i    (s_axis_tdata[MODE_W-1:0]),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  tcbm_datapath #(
    .MaxVertices(MaxVertices),
    .IdxW       (IdxW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .src_vertex_i   (s_axis_tdata[MODE_W +: VERTEX_W]),
    .dst_vertex_i   (s_axis_tdata[MODE_W + VERTEX_W +: VERTEX_W]),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .row_vertex_o   (row_vertex),
    .adjacency_row_o(adjacency_row),
    .reach_row_o    (reach_row),
    .last_row_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {(M_TDATA_W - M_FIELDS_W)'(0), reach_row, adjacency_row, row_vertex};

endmodule

[rtl/tcbm_ctrl.sv]
// Sequencer for matrix updates, closure passes and row emission.
module tcbm_ctrl
  import tcbm_pkg::*;
#(
  parameter int MaxVertices = MAX_VERTICES_DEF,
  parameter int IdxW        = $clog2(MaxVertices)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic              in_ready_o,
  input  status_t           status_i,
  output cmd_t              cmd_o,
  output logic [IdxW-1:0]   idx_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  mode_e           mode;
  logic            accept;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_o      = idx_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_CLEAR: cmd_o.clear    = 1'b1;
            MODE_EDGE:  cmd_o.add_edge = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_CLOSE: cmd_o.step     = 1'b1;
      ST_EMIT:  cmd_o.load_out = status_i.out_free;
      default:  ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode == MODE_CLOSE) begin
          state_d = ST_CLOSE;
          idx_d   = '0;
        end
      end
      ST_CLOSE: begin
        if (status_i.idx_last) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        // advance only when the output register takes the row
        if (status_i.out_free) begin
          if (status_i.idx_last) begin
            state_d = ST_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

[rtl/tcbm_datapath.sv]
// Bit matrices, row-parallel closure update, vertex count register and output register.
module tcbm_datapath
  import tcbm_pkg::*;
#(
  parameter int MaxVertices = MAX_VERTICES_DEF,
  parameter int IdxW        = $clog2(MaxVertices)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VERTEX_W-1:0] cfg_wdata_i,
  input  logic [VERTEX_W-1:0] src_vertex_i,
  input  logic [VERTEX_W-1:0] dst_vertex_i,
  input  cmd_t                cmd_i,
  input  logic [IdxW-1:0]     idx_i,
  output status_t             status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VERTEX_W-1:0] row_vertex_o,
  output logic [ROW_W-1:0]    adjacency_row_o,
  output logic [ROW_W-1:0]    reach_row_o,
  output logic                last_row_o
);

  localparam int CmpW = VERTEX_W + 1;
  localparam int ExtW = (MaxVertices > ROW_W) ? MaxVertices : ROW_W;

  logic [VERTEX_W-1:0]    vertex_count_q;
  logic [MaxVertices-1:0] adj_q   [MaxVertices];
  logic [MaxVertices-1:0] reach_q [MaxVertices];

  logic [IdxW-1:0]        n_m1;
  logic [MaxVertices-1:0] col_mask;
  logic [MaxVertices-1:0] krow;
  logic                   edge_ok;
  logic [IdxW-1:0]        src_idx, dst_idx;
  logic [ExtW-1:0]        adj_ext, reach_ext;

  logic                   out_valid_q;
  logic [VERTEX_W-1:0]    row_vertex_q;
  logic [ROW_W-1:0]       adj_row_q, reach_row_q;
  logic                   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // clamp the vertex count to 1..MaxVertices, held as n-1
  always_comb begin
    if (vertex_count_q == '0) begin
      n_m1 = '0;
    end else if (CmpW'(vertex_count_q) > CmpW'(MaxVertices)) begin
      n_m1 = IdxW'(MaxVertices - 1);
    end else begin
      n_m1 = IdxW'(vertex_count_q - VERTEX_W'(1));
    end
  end

  for (genvar i = 0; i < MaxVertices; i++) begin : g_mask
    assign col_mask[i] = (IdxW'(i) <= n_m1);
  end

  assign edge_ok = (src_vertex_i != '0) && (dst_vertex_i != '0)
                && (CmpW'(src_vertex_i) <= CmpW'(n_m1) + CmpW'(1))
                && (CmpW'(dst_vertex_i) <= CmpW'(n_m1) + CmpW'(1));
  assign src_idx = IdxW'(src_vertex_i - VERTEX_W'(1));
  assign dst_idx = IdxW'(dst_vertex_i - VERTEX_W'(1));

  assign krow = reach_q[idx_i] & col_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < MaxVertices; u++) begin
        adj_q[u]   <= '0;
        reach_q[u] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int u = 0; u < MaxVertices; u++) begin
        adj_q[u]   <= '0;
        reach_q[u] <= '0;
      end
    end else if (cmd_i.add_edge && edge_ok) begin
      adj_q[src_idx][dst_idx]   <= 1'b1;
      reach_q[src_idx][dst_idx] <= 1'b1;
    end else if (cmd_i.step) begin
      // every active row that reaches k picks up row k
      for (int u = 0; u < MaxVertices; u++) begin
        if (col_mask[u] && reach_q[u][idx_i]) begin
          reach_q[u] <= reach_q[u] | krow;
        end
      end
    end
  end

  assign adj_ext   = ExtW'(adj_q[idx_i] & col_mask);
  assign reach_ext = ExtW'(reach_q[idx_i] & col_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      row_vertex_q <= VERTEX_W'(idx_i) + VERTEX_W'(1);
      adj_row_q    <= adj_ext[ROW_W-1:0];
      reach_row_q  <= reach_ext[ROW_W-1:0];
      last_q       <= (idx_i == n_m1);
    end
  end

  assign status_o.idx_last = (idx_i == n_m1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign row_vertex_o    = row_vertex_q;
  assign adjacency_row_o = adj_row_q;
  assign reach_row_o     = reach_row_q;
  assign last_row_o      = last_q;

endmodule

[rtl/tcbm_checker.sv]
// Port-level checks for the transitive closure core, bound to the top level.
module tcbm_checker
  import tcbm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  logic s_acc;
  logic close_acc;
  logic short_acc;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign close_acc = s_acc && (s_axis_tdata[MODE_W-1:0] == MODE_CLOSE);
  assign short_acc = s_acc && (s_axis_tdata[MODE_W-1:0] != MODE_CLOSE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_acc |=> !s_axis_tready)
    else $error("closure request did not block the input");

  a_short_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    short_acc |=> s_axis_tready)
    else $error("clear or edge word stalled the input");

endmodule

bind transitive_closure_bit_matrix_core tcbm_checker u_tcbm_checker (.*);

[verif/transitive_closure_bit_matrix_core_tb.sv]
// Self-checking testbench for the transitive closure core: directed and random graphs.
module transitive_closure_bit_matrix_core_tb;
  import tcbm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int HOLDOFF_LEN  = 400;
  localparam int RANDOM_ITEMS = 150;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [ROW_W-1:0]    adj;
    logic [ROW_W-1:0]    reach;
    logic                last;
  } row_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [VERTEX_W-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Graph model
  logic [ROW_W-1:0]    adj_mat   [MAX_VERTICES_DEF];
  logic [ROW_W-1:0]    reach_mat [MAX_VERTICES_DEF];
  logic [VERTEX_W-1:0] vcount_model = VCOUNT_RESET;
  row_word_t           pending_rows [$];

  int  words_sent = 0;
  int  rows_checked = 0;
  int  closures_sent = 0;
  int  mismatches = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  holdoff_requests = 0;
  int  holdoff_served = 0;
  int  hold_left = 0;
  int  rx_gap_left = 0;

  transitive_closure_bit_matrix_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int effective_count(logic [VERTEX_W-1:0] vc);
    if (vc == 0) return 1;
    if (vc > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return int'(vc);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_graph_model();
    for (int v = 0; v < MAX_VERTICES_DEF; v++) begin
      adj_mat[v]   = '0;
      reach_mat[v] = '0;
    end
  endfunction

  // Apply one accepted command to the graph model; a closure queues its rows.
  function automatic void update_graph_model(logic [MODE_W-1:0] mode,
                                             logic [VERTEX_W-1:0] src,
                                             logic [VERTEX_W-1:0] dst);
    int               n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] krow;
    row_word_t        row;
    n = effective_count(vcount_model);
    mask = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - 1);
    case (mode)
      MODE_CLEAR: reset_graph_model();
      MODE_EDGE: begin
        if (src >= 1 && src <= n && dst >= 1 && dst <= n) begin
          adj_mat[src-1][dst-1]   = 1'b1;
          reach_mat[src-1][dst-1] = 1'b1;
        end
      end
      MODE_CLOSE: begin
        for (int k = 0; k < n; k++) begin
          krow = reach_mat[k] & mask;
          for (int u = 0; u < n; u++)
            if (reach_mat[u][k]) reach_mat[u] |= krow;
        end
        for (int u = 0; u < n; u++) begin
          row.vertex = VERTEX_W'(u + 1);
          row.adj    = adj_mat[u] & mask;
          row.reach  = reach_mat[u] & mask;
          row.last   = (u + 1 == n);
          pending_rows.push_back(row);
        end
      end
      default: ;
    endcase
  endfunction

  // Send one command word; returns right after the accepting edge.
  task automatic send_command(logic [MODE_W-1:0] mode, logic [VERTEX_W-1:0] src,
                              logic [VERTEX_W-1:0] dst);
    int gap;
    @(negedge clk_i);
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dst, src, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (mode == MODE_CLOSE) closures_sent++;
    update_graph_model(mode, src, dst);
  endtask

  task automatic add_edge(int src, int dst);
    send_command(MODE_EDGE, VERTEX_W'(src), VERTEX_W'(dst));
  endtask

  task automatic request_closure();
    send_command(MODE_CLOSE, VERTEX_W'($urandom), VERTEX_W'($urandom));
  endtask

  task automatic clear_graph();
    send_command(MODE_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
  endtask

  // Drop valid and wait for every queued row plus the core's tail latency.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(logic [VERTEX_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_model = value;
  endtask

  // Receiver: long hold-off on request, otherwise random short and long stalls.
  always @(negedge clk_i) begin
    if (holdoff_requests != holdoff_served) begin
      holdoff_served = holdoff_requests;
      hold_left = HOLDOFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_gap_left = rx_idle_on ? gap_len() : 0;
      m_axis_tready <= (rx_gap_left == 0);
      if (rx_gap_left > 0) rx_gap_left--;
    end
  end

  // Check each emitted row against the oldest predicted one.
  always @(posedge clk_i) begin
    row_word_t got;
    row_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.vertex = m_axis_tdata[5:0];
      got.adj    = m_axis_tdata[37:6];
      got.reach  = m_axis_tdata[69:38];
      got.last   = m_axis_tlast;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row word: v=%0d adj=%h reach=%h last=%b",
                   got.vertex, got.adj, got.reach, got.last);
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (got.vertex !== want.vertex || got.adj !== want.adj ||
            got.reach !== want.reach || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("row word differs: expected v=%0d adj=%h reach=%h last=%b,%s",
                     want.vertex, want.adj, want.reach, want.last,
                     $sformatf(" got v=%0d adj=%h reach=%h last=%b",
                               got.vertex, got.adj, got.reach, got.last));
        end
      end
    end
  end

  // Empty graph at the reset count, then extreme and out-of-range edges.
  task automatic test_reset_state();
    request_closure();
    add_edge(1, 32);
    add_edge(32, 1);
    add_edge(0, 5);
    add_edge(5, 0);
    add_edge(33, 1);
    add_edge(1, 63);
    send_command(MODE_UNUSED, 6'h3f, 6'h3f);
    request_closure();
  endtask

  // Count 0 acts as one vertex, counts above the maximum as the maximum;
  // the graph is kept across count changes, and a final clear empties it.
  task automatic test_vertex_count_limits();
    write_vertex_count(6'd0);
    add_edge(1, 1);
    add_edge(1, 2);
    request_closure();
    write_vertex_count(6'd63);
    add_edge(2, 3);
    add_edge(3, 4);
    add_edge(4, 2);
    request_closure();
    request_closure();
    write_vertex_count(6'd4);
    request_closure();
    write_vertex_count(6'd33);
    request_closure();
    clear_graph();
    request_closure();
  endtask

  task automatic test_random_graphs();
    logic [VERTEX_W-1:0] counts [12] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7,
                                         6'd8, 6'd12, 6'd16, 6'd32, 6'd0, 6'd40};
    int start;
    int n;
    int r;
    start = words_sent;
    while (words_sent - start < RANDOM_ITEMS) begin
      write_vertex_count(counts[$urandom_range(0, 11)]);
      n = effective_count(vcount_model);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) clear_graph();
      repeat ($urandom_range(1, 14)) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          add_edge($urandom_range(1, n), $urandom_range(1, n));
        else if (r < 90)
          send_command(MODE_EDGE, VERTEX_W'($urandom), VERTEX_W'($urandom));
        else if (r < 95)
          send_command(MODE_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
        else
          request_closure();
      end
      request_closure();
      if ($urandom_range(0, 3) == 0) request_closure();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the receiver off while closures keep arriving; the core must stall.
  task automatic test_output_backpressure();
    write_vertex_count(6'd32);
    tx_idle_on = 1'b0;
    holdoff_requests++;
    clear_graph();
    for (int v = 1; v < 32; v++) add_edge(v, v + 1);
    request_closure();
    add_edge(32, 1);
    request_closure();
    request_closure();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    reset_graph_model();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_vertex_count_limits();
    test_output_backpressure();
    test_random_graphs();
    wait_idle();
    repeat (2 * MAX_VERTICES_DEF + 8) @(posedge clk_i);
    if (pending_rows.size() != 0) mismatches++;
    $display("Sent %0d command words, %0d of them closures; checked %0d rows.",
             words_sent, closures_sent, rows_checked);
    $display("Vertex counts swept from 0 to 63, %0d row failures, %0d rows left over.",
             mismatches, pending_rows.size());
    if (mismatches == 0)
      $display("transitive_closure_bit_matrix_core: match");
    else
      $display("transitive_closure_bit_matrix_core: mismatch");
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 600000);
    $display("transitive_closure_bit_matrix_core: mismatch");
    $finish;
  end

endmodule

[transitive_closure_bit_matrix_core.f]
rtl/tcbm_pkg.sv
rtl/tcbm_ctrl.sv
rtl/tcbm_datapath.sv
rtl/transitive_closure_bit_matrix_core.sv
rtl/tcbm_checker.sv
verif/transitive_closure_bit_matrix_core_tb.sv
